/* src/cgmv_pkg.sv */
// Shared codes, widths and the command record passed from the front end to the back end.
`timescale 1ns / 1ps
package cgmv_pkg;

  localparam int OP_W     = 4;
  localparam int LEN_W    = 16;
  localparam int OFS_W    = 16;
  localparam int GPOS_W   = 32;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // CIGAR operation codes that need their own handling; all others advance the cursors.
  localparam logic [OP_W-1:0] OP_INS  = 4'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 4'd2;
  localparam logic [OP_W-1:0] OP_SOFT = 4'd4;
  localparam logic [OP_W-1:0] OP_MISM = 4'd7;

  // Variant record kinds.
  localparam logic [KIND_W-1:0] KIND_INS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUB = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REF_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GENOME_START = 2'd2;

  // Bit positions in the record mask of a command, in emission order.
  localparam int REC_INS = 0;
  localparam int REC_DEL = 1;
  localparam int REC_SUB = 2;
  localparam int REC_N   = 3;

  typedef struct packed {
    logic [OFS_W-1:0]  base_ref;
    logic [OFS_W-1:0]  base_query;
    logic [GPOS_W-1:0] base_genome;
    logic [LEN_W-1:0]  ins_total;
    logic [LEN_W-1:0]  del_total;
    logic [LEN_W-1:0]  op_len;
    logic [REC_N-1:0]  rec_mask;
  } gap_cmd_t;

endpackage

/* src/cgmv_front.sv */
// Front end: takes CIGAR operations, merges gaps, tracks the cursors and issues record commands.
`timescale 1ns / 1ps
module cgmv_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cgmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgmv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          op_valid,
  output logic                          op_stall,
  input  logic [cgmv_pkg::OP_W-1:0]     op_code,
  input  logic [cgmv_pkg::LEN_W-1:0]    op_length,
  input  logic                          last_op,
  input  logic                          queue_full,
  output logic                          cmd_push,
  output cgmv_pkg::gap_cmd_t            cmd
);
  import cgmv_pkg::*;

  logic [OFS_W-1:0]  ref_load;
  logic [OFS_W-1:0]  query_load;
  logic [GPOS_W-1:0] genome_load;
  logic [OFS_W-1:0]  ref_cursor;
  logic [OFS_W-1:0]  query_cursor;
  logic [GPOS_W-1:0] genome_cursor;
  logic [LEN_W-1:0]  pending_insert_total;
  logic [LEN_W-1:0]  pending_delete_total;
  logic              insert_pending;
  logic              delete_pending;
  logic              in_alignment;

  logic              accept;
  logic [OFS_W-1:0]  cur_ref;
  logic [OFS_W-1:0]  cur_query;
  logic [GPOS_W-1:0] cur_genome;
  logic              is_ins;
  logic              is_del;
  logic              is_gap;
  logic              advance;
  logic              flush;
  logic [LEN_W-1:0]  ins_acc;
  logic [LEN_W-1:0]  del_acc;
  logic              ins_flag;
  logic              del_flag;
  logic              ins_en;
  logic              del_en;
  logic [LEN_W-1:0]  ins_amt;
  logic [LEN_W-1:0]  del_amt;
  logic [LEN_W-1:0]  adv_len;
  logic [OFS_W-1:0]  ref_cursor_next;
  logic [OFS_W-1:0]  query_cursor_next;
  logic [GPOS_W-1:0] genome_cursor_next;

  assign op_stall = queue_full;
  assign accept   = op_valid && !op_stall;

  always_comb begin
    // The first operation of an alignment starts from the configured origin.
    cur_ref    = in_alignment ? ref_cursor    : ref_load;
    cur_query  = in_alignment ? query_cursor  : query_load;
    cur_genome = in_alignment ? genome_cursor : genome_load;

    is_ins  = (op_code == OP_INS);
    is_del  = (op_code == OP_DEL);
    is_gap  = is_ins || is_del;
    advance = !is_gap && (op_code != OP_SOFT);
    flush   = !is_gap || last_op;

    ins_acc  = pending_insert_total + (is_ins ? op_length : '0);
    del_acc  = pending_delete_total + (is_del ? op_length : '0);
    ins_flag = insert_pending || is_ins;
    del_flag = delete_pending || is_del;
    ins_en   = flush && ins_flag;
    del_en   = flush && del_flag;
    ins_amt  = ins_en ? ins_acc : '0;
    del_amt  = del_en ? del_acc : '0;
    adv_len  = advance ? op_length : '0;

    query_cursor_next  = cur_query + ins_amt + adv_len;
    ref_cursor_next    = cur_ref + del_amt + adv_len;
    genome_cursor_next = cur_genome + GPOS_W'(del_amt) + GPOS_W'(adv_len);

    cmd.base_ref    = cur_ref;
    cmd.base_query  = cur_query;
    cmd.base_genome = cur_genome;
    cmd.ins_total   = ins_amt;
    cmd.del_total   = del_amt;
    cmd.op_len      = op_length;
    cmd.rec_mask[REC_INS] = ins_en;
    cmd.rec_mask[REC_DEL] = del_en;
    cmd.rec_mask[REC_SUB] = (op_code == OP_MISM);

    cmd_push = accept && (cmd.rec_mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_load             <= '0;
      query_load           <= '0;
      genome_load          <= '0;
      ref_cursor           <= '0;
      query_cursor         <= '0;
      genome_cursor        <= '0;
      pending_insert_total <= '0;
      pending_delete_total <= '0;
      insert_pending       <= 1'b0;
      delete_pending       <= 1'b0;
      in_alignment         <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_REF_START:    ref_load   <= cfg_data[OFS_W-1:0];
          CFG_QUERY_START:  query_load <= cfg_data[OFS_W-1:0];
          // Held already converted to a zero-based position.
          CFG_GENOME_START: genome_load <= (cfg_data == '0) ? '0 : cfg_data - 1'b1;
          default: ;
        endcase
      end
      if (accept) begin
        ref_cursor           <= ref_cursor_next;
        query_cursor         <= query_cursor_next;
        genome_cursor        <= genome_cursor_next;
        pending_insert_total <= flush ? '0 : ins_acc;
        pending_delete_total <= flush ? '0 : del_acc;
        insert_pending       <= flush ? 1'b0 : ins_flag;
        delete_pending       <= flush ? 1'b0 : del_flag;
        in_alignment         <= !last_op;
      end
    end
  end

endmodule

/* src/cgmv_queue.sv */
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module cgmv_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cgmv_pkg::gap_cmd_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output cgmv_pkg::gap_cmd_t head
);
  import cgmv_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  gap_cmd_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/cgmv_back.sv */
// Back end: expands each command into its variant records and holds them in the output register.
`timescale 1ns / 1ps
module cgmv_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  cgmv_pkg::gap_cmd_t          head,
  output logic                        pop,
  output logic                        variant_valid,
  input  logic                        variant_stall,
  output logic [cgmv_pkg::KIND_W-1:0] variant_kind,
  output logic [cgmv_pkg::GPOS_W-1:0] genomic_position,
  output logic [cgmv_pkg::OFS_W-1:0]  ref_offset,
  output logic [cgmv_pkg::OFS_W-1:0]  query_offset,
  output logic [cgmv_pkg::LEN_W-1:0]  variant_length,
  output logic                        last_result
);
  import cgmv_pkg::*;

  logic [REC_N-1:0]  done;
  logic [REC_N-1:0]  remaining;
  logic [REC_N-1:0]  sel;
  logic              sel_last;
  logic              load;
  logic [KIND_W-1:0] kind_sel;
  logic [GPOS_W-1:0] gpos_sel;
  logic [OFS_W-1:0]  ref_sel;
  logic [OFS_W-1:0]  query_sel;
  logic [LEN_W-1:0]  len_sel;

  always_comb begin
    remaining = head.rec_mask & ~done;
    // Records leave in the order insertion, deletion, substitution.
    if (remaining[REC_INS]) begin
      sel = REC_N'(1) << REC_INS;
    end else if (remaining[REC_DEL]) begin
      sel = REC_N'(1) << REC_DEL;
    end else begin
      sel = REC_N'(1) << REC_SUB;
    end
    sel_last = ((remaining & ~sel) == '0);
    load     = head_valid && (!variant_valid || !variant_stall);
    pop      = load && sel_last;

    kind_sel  = KIND_SUB;
    gpos_sel  = head.base_genome + GPOS_W'(head.del_total);
    ref_sel   = head.base_ref + head.del_total;
    query_sel = head.base_query + head.ins_total;
    len_sel   = head.op_len;
    case (1'b1)
      sel[REC_INS]: begin
        kind_sel  = KIND_INS;
        gpos_sel  = head.base_genome;
        ref_sel   = head.base_ref;
        query_sel = head.base_query;
        len_sel   = head.ins_total;
      end
      sel[REC_DEL]: begin
        kind_sel  = KIND_DEL;
        gpos_sel  = head.base_genome;
        ref_sel   = head.base_ref;
        len_sel   = head.del_total;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      variant_kind     <= kind_sel;
      genomic_position <= gpos_sel;
      ref_offset       <= ref_sel;
      query_offset     <= query_sel;
      variant_length   <= len_sel;
      last_result      <= sel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      variant_valid <= 1'b0;
      done          <= '0;
    end else begin
      if (load) begin
        variant_valid <= 1'b1;
        done          <= sel_last ? '0 : (done | sel);
      end else if (!variant_stall) begin
        variant_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/cigar_gap_merge_variant_walker.sv */
// Top level of the CIGAR gap-merging variant walker.
`timescale 1ns / 1ps
// The walker takes one parsed CIGAR operation per transfer and returns a variant record for
// every merged insertion, merged deletion and mismatch run, with its zero-based genomic
// position, reference and query offsets and length. Adjacent I and D operations are merged
// into one insertion record followed by one deletion record, flushed by the next non-gap
// operation or by the last operation of the alignment. A front end accepts one operation per
// clock cycle while the queue is not full, keeps the cursors and pending gap totals, and hands
// each operation that causes records to a command queue (QUEUE_DEPTH entries). The back end
// expands a command into its records, one per cycle while the output is not stalled, into an
// output register. An operation causes up to three records, for a mismatch that closes a gap
// run, so the single record emitted per cycle in the back end limits the sustained throughput.
// Operations that cause no record never reach the queue. The input stalls only while the
// queue is full. The user must see that the start offsets and genomic start are written
// through the configuration port only while the block is idle; the block itself does not
// enforce this. They take effect at the first operation of the next alignment. Totals and
// offsets wrap at 16 bits and the genomic position at 32 bits.
module cigar_gap_merge_variant_walker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cgmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgmv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            op_valid,
  output logic                            op_stall,
  input  logic [cgmv_pkg::OP_W-1:0]       op_code,
  input  logic [cgmv_pkg::LEN_W-1:0]      op_length,
  input  logic                            last_op,
  output logic                            variant_valid,
  input  logic                            variant_stall,
  output logic [cgmv_pkg::KIND_W-1:0]     variant_kind,
  output logic [cgmv_pkg::GPOS_W-1:0]     genomic_position,
  output logic [cgmv_pkg::OFS_W-1:0]      ref_offset,
  output logic [cgmv_pkg::OFS_W-1:0]      query_offset,
  output logic [cgmv_pkg::LEN_W-1:0]      variant_length,
  output logic                            last_result
);
  import cgmv_pkg::*;

  // Command from the front end and the head of the queue towards the back end.
  gap_cmd_t cmd;
  gap_cmd_t head;
  logic     cmd_push;
  logic     queue_full;
  logic     head_valid;
  logic     pop;

  // The front end owns the configuration registers and all cursor state.
  cgmv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op_valid   (op_valid),
    .op_stall   (op_stall),
    .op_code    (op_code),
    .op_length  (op_length),
    .last_op    (last_op),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd)
  );

  // Each entry carries the cursors before the operation and the gap totals, so the back end
  // can form every record's fields with one add.
  cgmv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_data  (cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end marks the final record of each operation with last_result.
  cgmv_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .variant_valid    (variant_valid),
    .variant_stall    (variant_stall),
    .variant_kind     (variant_kind),
    .genomic_position (genomic_position),
    .ref_offset       (ref_offset),
    .query_offset     (query_offset),
    .variant_length   (variant_length),
    .last_result      (last_result)
  );

endmodule

/* test/tb_cigar_gap_merge_variant_walker.sv */
// Self-checking testbench for the CIGAR gap-merging variant walker.
`timescale 1ns / 1ps
// The bench feeds CIGAR operations to the walker and compares every variant record that comes
// back with the record its own walker model predicts. It starts with a short table of directed
// operations: gap merging, zero-length gaps, 16-bit wrap of lengths and offsets, undefined
// operation codes, the last-operation flush of a trailing gap run and the reload of the cursors
// at the next alignment. A few rows carry the record that is expected, typed in by hand. Then it
// runs eight phases of random alignments with some noise. Each phase writes some or all registers
// first, while the block is idle, and sets one idling pattern on the two channels. One phase
// also holds the output off for a long stretch so that the command queue fills and the input
// stalls. Between phases the sender pauses until every predicted record has been transferred.
module tb_cigar_gap_merge_variant_walker;
  import cgmv_pkg::*;

  // CIGAR codes that the package leaves out because the block treats them all alike.
  localparam logic [OP_W-1:0] OP_MATCH    = 4'd0;
  localparam logic [OP_W-1:0] OP_SKIP     = 4'd3;
  localparam logic [OP_W-1:0] OP_HARD     = 4'd5;
  localparam logic [OP_W-1:0] OP_PAD      = 4'd6;
  localparam logic [OP_W-1:0] OP_EQUAL    = 4'd8;
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;

  // Register index beyond the three registers; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int N_DIRECTED     = 24;
  localparam int N_PHASES       = 8;
  localparam int PHASE_OPS      = 30;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [GPOS_W-1:0] gpos;
    logic [OFS_W-1:0]  rofs;
    logic [OFS_W-1:0]  qofs;
    logic [LEN_W-1:0]  len;
    logic              last;
  } variant_rec_t;

  // One row of the directed table. Where typed is set, n_recs and first give the number of
  // records the operation must cause and the first of them.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             typed;
    logic [1:0]       n_recs;
    variant_rec_t     first;
  } cigar_row_t;

  localparam variant_rec_t NO_REC = '0;

  // The registers are at reset (all zero) while this table is walked, so every alignment
  // begins at genomic position zero with both offsets zero.
  localparam cigar_row_t DIRECTED_OPS [N_DIRECTED] = '{
    '{OP_MISM,     16'd5,     1'b0, 1'b1, 2'd1,
      '{KIND_SUB, 32'd0, 16'd0, 16'd0, 16'd5, 1'b1}},
    '{OP_INS,      16'd3,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_DEL,      16'd2,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_INS,      16'd1,     1'b0, 1'b0, 2'd0, NO_REC},
    // The match closes the gap run: one insertion of four, then one deletion of two.
    '{OP_MATCH,    16'd10,    1'b0, 1'b1, 2'd2,
      '{KIND_INS, 32'd5, 16'd5, 16'd5, 16'd4, 1'b0}},
    '{OP_SOFT,     16'hFFFF,  1'b0, 1'b1, 2'd0, NO_REC},
    '{OP_MISM,     16'hFFFF,  1'b0, 1'b1, 2'd1,
      '{KIND_SUB, 32'd17, 16'd17, 16'd19, 16'hFFFF, 1'b1}},
    // Both offsets have wrapped past 16 bits; the genomic position has not.
    '{OP_DEL,      16'd0,     1'b1, 1'b1, 2'd1,
      '{KIND_DEL, 32'd65552, 16'd16, 16'd18, 16'd0, 1'b1}},
    '{OP_HARD,     16'd1,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_PAD,      16'd2,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_SKIP,     16'd3,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_EQUAL,    16'd4,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_UNDEF_LO, 16'd1,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_UNDEF_HI, 16'hFFFF,  1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_INS,      16'hFFFF,  1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_INS,      16'd1,     1'b0, 1'b0, 2'd0, NO_REC},
    // The insertion total has wrapped to zero, yet the record is still emitted.
    '{OP_MISM,     16'd0,     1'b1, 1'b1, 2'd2,
      '{KIND_INS, 32'd65546, 16'd10, 16'd10, 16'd0, 1'b0}},
    '{OP_INS,      16'd7,     1'b1, 1'b1, 2'd1,
      '{KIND_INS, 32'd0, 16'd0, 16'd0, 16'd7, 1'b1}},
    '{OP_MATCH,    16'd0,     1'b1, 1'b1, 2'd0, NO_REC},
    '{OP_SOFT,     16'd5,     1'b1, 1'b1, 2'd0, NO_REC},
    '{OP_DEL,      16'd4,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_INS,      16'd2,     1'b0, 1'b0, 2'd0, NO_REC},
    '{OP_MISM,     16'd1,     1'b1, 1'b1, 2'd3,
      '{KIND_INS, 32'd0, 16'd0, 16'd0, 16'd2, 1'b0}},
    '{OP_DEL,      16'hFFFF,  1'b1, 1'b1, 2'd1,
      '{KIND_DEL, 32'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1}}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  op_valid = 1'b0;
  logic                  op_stall;
  logic [OP_W-1:0]       op_code = '0;
  logic [LEN_W-1:0]      op_length = '0;
  logic                  last_op = 1'b0;
  logic                  variant_valid;
  logic                  variant_stall = 1'b0;
  logic [KIND_W-1:0]     variant_kind;
  logic [GPOS_W-1:0]     genomic_position;
  logic [OFS_W-1:0]      ref_offset;
  logic [OFS_W-1:0]      query_offset;
  logic [LEN_W-1:0]      variant_length;
  logic                  last_result;

  cigar_gap_merge_variant_walker u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .op_valid         (op_valid),
    .op_stall         (op_stall),
    .op_code          (op_code),
    .op_length        (op_length),
    .last_op          (last_op),
    .variant_valid    (variant_valid),
    .variant_stall    (variant_stall),
    .variant_kind     (variant_kind),
    .genomic_position (genomic_position),
    .ref_offset       (ref_offset),
    .query_offset     (query_offset),
    .variant_length   (variant_length),
    .last_result      (last_result)
  );

  always #1 clk = ~clk;

  // Walker model: a copy of the registers, the three cursors and the open gap run.
  logic [OFS_W-1:0]  reg_ref_start;
  logic [OFS_W-1:0]  reg_query_start;
  logic [GPOS_W-1:0] reg_genome_start;
  logic [OFS_W-1:0]  ref_cur;
  logic [OFS_W-1:0]  query_cur;
  logic [GPOS_W-1:0] genome_cur;
  logic [LEN_W-1:0]  ins_total;
  logic [LEN_W-1:0]  del_total;
  logic              ins_open;
  logic              del_open;
  logic              in_alignment;

  // Records still owed by the block, oldest first. The newest record of an operation is held
  // back until the operation is complete, since only then is it known to be the last one.
  variant_rec_t expected_variants[$];
  variant_rec_t held_rec;
  variant_rec_t first_rec;
  logic         held_valid;
  int           step_recs;

  // Run bookkeeping.
  int mismatches = 0;
  int records_checked = 0;
  int ops_walked = 0;
  int cfg_writes = 0;
  int input_stalled = 0;
  int idle_cycles = 0;
  int kind_count [4];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int holds_begun = 0;
  int hold_left = 0;

  function automatic void reset_walker();
    reg_ref_start    = '0;
    reg_query_start  = '0;
    reg_genome_start = '0;
    ins_total        = '0;
    del_total        = '0;
    ins_open         = 1'b0;
    del_open         = 1'b0;
    in_alignment     = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_REF_START:    reg_ref_start = data[OFS_W-1:0];
      CFG_QUERY_START:  reg_query_start = data[OFS_W-1:0];
      CFG_GENOME_START: reg_genome_start = data[GPOS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void note_variant(input logic [KIND_W-1:0] kind,
                                       input logic [LEN_W-1:0] len);
    if (held_valid) expected_variants = {expected_variants, held_rec};
    held_rec = '{kind, genome_cur, ref_cur, query_cur, len, 1'b0};
    held_valid = 1'b1;
    if (step_recs == 0) first_rec = held_rec;
    step_recs++;
  endfunction

  // The insertion record goes first and moves only the query; the deletion record follows
  // and moves the reference and the genome.
  function automatic void flush_gaps();
    if (ins_open) begin
      note_variant(KIND_INS, ins_total);
      query_cur = query_cur + ins_total;
    end
    if (del_open) begin
      note_variant(KIND_DEL, del_total);
      ref_cur = ref_cur + del_total;
      genome_cur = genome_cur + del_total;
    end
    ins_total = '0;
    del_total = '0;
    ins_open = 1'b0;
    del_open = 1'b0;
  endfunction

  function automatic void advance_cursors(input logic [LEN_W-1:0] len);
    ref_cur = ref_cur + len;
    query_cur = query_cur + len;
    genome_cur = genome_cur + len;
  endfunction

  // Works out the records caused by one transferred operation and queues them.
  function automatic void walk_cigar_op(input logic [OP_W-1:0] op,
                                        input logic [LEN_W-1:0] len, input logic last);
    step_recs = 0;
    held_valid = 1'b0;
    first_rec = NO_REC;
    // The cursors are loaded from the registers at the first operation of an alignment.
    if (!in_alignment) begin
      ref_cur = reg_ref_start;
      query_cur = reg_query_start;
      genome_cur = (reg_genome_start != '0) ? reg_genome_start - 1 : '0;
    end
    in_alignment = 1'b1;
    if (op == OP_INS) begin
      ins_total = ins_total + len;
      ins_open = 1'b1;
    end else if (op == OP_DEL) begin
      del_total = del_total + len;
      del_open = 1'b1;
    end else begin
      flush_gaps();
      if (op == OP_MISM) begin
        note_variant(KIND_SUB, len);
        advance_cursors(len);
      end else if (op != OP_SOFT) begin
        advance_cursors(len);
      end
    end
    // A last operation flushes any gap run still open, even one it has just extended.
    if (last) begin
      flush_gaps();
      in_alignment = 1'b0;
    end
    if (held_valid) begin
      held_rec.last = 1'b1;
      if (step_recs == 1) first_rec = held_rec;
      expected_variants = {expected_variants, held_rec};
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Compares one transferred record with the oldest record still owed, field by field.
  task automatic take_variant();
    variant_rec_t got;
    variant_rec_t want;
    string wrong;
    got = '{variant_kind, genomic_position, ref_offset, query_offset, variant_length,
            last_result};
    records_checked++;
    kind_count[got.kind]++;
    if (expected_variants.size() == 0) begin
      report_mismatch($sformatf("record %0d arrived with none owed: kind %0d pos %0d",
                                records_checked, got.kind, got.gpos));
    end else begin
      want = expected_variants.pop_front();
      wrong = "";
      if (got.kind != want.kind)
        wrong = {wrong, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.gpos != want.gpos)
        wrong = {wrong, $sformatf(" genomic_position %0d/%0d", got.gpos, want.gpos)};
      if (got.rofs != want.rofs)
        wrong = {wrong, $sformatf(" ref_offset %0d/%0d", got.rofs, want.rofs)};
      if (got.qofs != want.qofs)
        wrong = {wrong, $sformatf(" query_offset %0d/%0d", got.qofs, want.qofs)};
      if (got.len != want.len)
        wrong = {wrong, $sformatf(" variant_length %0d/%0d", got.len, want.len)};
      if (got.last != want.last)
        wrong = {wrong, $sformatf(" last_result %0d/%0d", got.last, want.last)};
      if (wrong != "")
        report_mismatch($sformatf("record %0d got/expected:%s", records_checked, wrong));
    end
  endtask

  // Receiving side. Outputs are sampled just after the edge, so they still hold the values
  // that the edge itself saw. A long hold-off, when asked for, is counted out here.
  always @(posedge clk) begin
    if (variant_valid && !variant_stall) take_variant();
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      variant_stall <= 1'b1;
    end else if (hold_asks != holds_begun) begin
      holds_begun <= hold_asks;
      hold_left <= HOLD_CYCLES;
      variant_stall <= 1'b1;
    end else begin
      variant_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Ends the run if neither channel completes a transfer for too long.
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (op_valid && op_stall) input_stalled++;
      if (rst || (op_valid && !op_stall) || (variant_valid && !variant_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer on either channel for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_cigar_gap_merge_variant_walker NOT OK");
    $finish;
  end

  // Offers one operation, holds it until it is transferred and then updates the model.
  // Always called, and always returns, just after a rising edge.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                         input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op_valid  <= 1'b1;
    op_code   <= op;
    op_length <= len;
    last_op   <= last;
    @(posedge clk);
    while (op_stall) @(posedge clk);
    walk_cigar_op(op, len, last);
    ops_walked++;
  endtask

  // Stops offering and waits until every owed record has been transferred, then lets the
  // block run on for a while in case it still has something in hand.
  task automatic wait_for_quiet();
    op_valid <= 1'b0;
    while (expected_variants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it once the last write is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_writes++;
  endtask

  // The first phases take the extremes; later ones take random values with random upper
  // bits, which the 16-bit registers must drop.
  task automatic configure_phase(input int phase);
    case (phase)
      0: begin
        write_reg(CFG_REF_START, 32'h0000_FFFF);
        write_reg(CFG_QUERY_START, 32'h0000_FFFF);
        write_reg(CFG_GENOME_START, 32'hFFFF_FFFF);
      end
      1: begin
        write_reg(CFG_REF_START, '0);
        write_reg(CFG_QUERY_START, '0);
        write_reg(CFG_GENOME_START, 32'd1);
      end
      2: begin
        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_GENOME_START, '0);
      end
      default: begin
        write_reg(CFG_REF_START, $urandom);
        write_reg(CFG_QUERY_START, $urandom);
        write_reg(CFG_GENOME_START, $urandom);
      end
    endcase
    cfg_write <= 1'b0;
  endtask

  // Mostly short runs, with a fair share of zero, full-scale and fully random lengths.
  function automatic logic [LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 12) return '1;
    if (roll < 20) return LEN_W'($urandom);
    return LEN_W'($urandom_range(40, 1));
  endfunction

  // Gaps and mismatches are weighted up so that merged runs of both kinds are common.
  function automatic logic [OP_W-1:0] pick_op();
    int roll;
    roll = $urandom_range(99);
    if (roll < 22) return OP_MATCH;
    if (roll < 36) return OP_INS;
    if (roll < 50) return OP_DEL;
    if (roll < 64) return OP_MISM;
    if (roll < 69) return OP_SOFT;
    if (roll < 76) return OP_EQUAL;
    if (roll < 80) return OP_SKIP;
    if (roll < 84) return OP_HARD;
    if (roll < 88) return OP_PAD;
    if (roll < 92) return OP_W'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
    return roll[0] ? OP_INS : OP_DEL;
  endfunction

  // A well-formed alignment: a handful of operations with the last flag on the final one.
  task automatic send_alignment();
    int n_ops;
    n_ops = $urandom_range(8, 1);
    for (int i = 0; i < n_ops; i++) send_op(pick_op(), pick_length(), i == n_ops - 1);
  endtask

  initial begin : stimulus
    cigar_row_t row;
    int phase_start;
    reset_walker();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, with both channels running freely.
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED_OPS[r];
      send_op(row.op, row.len, row.last);
      if (row.typed && (step_recs != row.n_recs || (step_recs != 0 && first_rec != row.first)))
        report_mismatch($sformatf("directed row %0d: model gives %0d records, first %p",
                                  r, step_recs, first_rec));
    end

    // Random phases. The idling pattern cycles through free running, an idle sender, a
    // stalling receiver, and both at a lighter rate.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_for_quiet();
      configure_phase(phase);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      // Once, the receiver holds off while the sender keeps offering gap runs that a mismatch
      // closes, each with three records, so the command queue fills and the input has to stall.
      if (phase == 2) begin
        hold_asks <= hold_asks + 1;
        for (int k = 0; k < 6; k++) begin
          send_op(OP_INS, pick_length(), 1'b0);
          send_op(OP_DEL, pick_length(), 1'b0);
          send_op(OP_MISM, pick_length(), 1'b1);
        end
      end
      phase_start = ops_walked;
      while (ops_walked - phase_start < PHASE_OPS) begin
        // Some noise: any code, any length and a last flag at random.
        if ($urandom_range(99) < 15)
          send_op(OP_W'($urandom_range(15)), LEN_W'($urandom), 1'($urandom_range(1)));
        else
          send_alignment();
      end
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_for_quiet();
    $display("Walked %0d CIGAR operations (%0d from the directed table) in %0d phases,",
             ops_walked, N_DIRECTED, N_PHASES);
    $display("%0d register writes, %0d records (%0d ins, %0d del, %0d sub), input stalled %0d.",
             cfg_writes, records_checked, kind_count[KIND_INS], kind_count[KIND_DEL],
             kind_count[KIND_SUB], input_stalled);
    if (mismatches == 0)
      $display("tb_cigar_gap_merge_variant_walker OK");
    else
      $display("tb_cigar_gap_merge_variant_walker NOT OK");
    $finish;
  end

endmodule
